### src/assert_macros.svh
// Assertion macros used by the framer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPF_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rpf_pkg.sv
// Shared types, constants and bit functions of the radio packet framer.
`default_nettype none

package rpf_pkg;

    localparam int MAX_PAYLOAD_DEF = 249;

    localparam logic [6:0]  PREAMBLE_MAX  = 7'd106;
    localparam logic [2:0]  FIELD_MAX     = 3'd4;
    localparam logic [8:0]  PN9_SEED      = 9'h1FF;
    localparam logic [7:0]  PRE_PLAIN_P1  = 8'h55;
    localparam logic [7:0]  PRE_PLAIN_P0  = 8'haa;
    localparam logic [7:0]  PRE_MANCH_P1  = 8'hff;
    localparam logic [7:0]  PRE_MANCH_P0  = 8'h00;
    localparam logic [7:0]  BYTE_INVERT   = 8'hff;

    localparam logic [15:0] POLY_TABLE [4] = '{16'h1021, 16'h8005, 16'h5B93, 16'h90D9};

    // Reset values of the configuration registers.
    localparam logic [6:0]  RST_PRE_NIB   = 7'd8;
    localparam logic [2:0]  RST_SYNC_LEN  = 3'd2;
    localparam logic [31:0] RST_SYNC      = 32'd765722624;
    localparam logic [2:0]  RST_HDR_LEN   = 3'd2;
    localparam logic [31:0] RST_HDR       = 32'd0;
    localparam logic [1:0]  RST_CRC_SEL   = 2'd1;
    localparam logic [7:0]  RST_MODE      = 8'd69;

    // Bit positions in mode_flags.
    localparam int MF_POLARITY = 0;
    localparam int MF_FIXED    = 1;
    localparam int MF_CRC_ON   = 2;
    localparam int MF_CRC_DATA = 3;
    localparam int MF_LSB      = 4;
    localparam int MF_MANCH    = 5;
    localparam int MF_MINV     = 6;
    localparam int MF_WHITE    = 7;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic [2:0] {
        REG_PRE_NIB  = 3'd0,
        REG_SYNC_LEN = 3'd1,
        REG_SYNC     = 3'd2,
        REG_HDR_LEN  = 3'd3,
        REG_HDR      = 3'd4,
        REG_CRC_SEL  = 3'd5,
        REG_MODE     = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        SRC_PRE,
        SRC_SYNC,
        SRC_HDR,
        SRC_LEN,
        SRC_DATA,
        SRC_CRC_HI,
        SRC_CRC_LO
    } src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_SYNC,
        ST_HDR,
        ST_LEN,
        ST_DATA,
        ST_CRC_HI,
        ST_CRC_LO
    } state_t;

    typedef struct packed {
        logic       emit;
        logic       start;
        logic       load_data;
        src_t       src;
        logic [1:0] idx;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic       slot_free;
        logic       len_zero;
        logic       rem_last;
        logic       crc_on;
        logic       fixed_len;
        logic [5:0] pre_cnt;
        logic [2:0] sync_cnt;
        logic [2:0] hdr_cnt;
    } dp_sts_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    // MSB-first CRC-16 over one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Eight PN9 steps.
    function automatic logic [8:0] pn9_step8(input logic [8:0] s);
        logic [8:0] t;
        t = s;
        for (int i = 0; i < 8; i++) begin
            t = {t[0] ^ t[5], t[8:1]};
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### src/rpf_ctrl.sv
// Frame sequencer: walks preamble, sync, header, length, data and CRC phases.
`default_nettype none

module rpf_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic            op,
    output logic                 s_tready,
    input  wire rpf_pkg::dp_sts_t sts,
    output rpf_pkg::dp_cmd_t     cmd
);
    import rpf_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       open_reg, open_next;
    logic       close_nocrc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            open_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            open_reg  <= open_next;
        end
    end

    // An empty payload without CRC ends the frame on the last start-item byte.
    assign close_nocrc = !sts.crc_on && sts.len_zero;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        open_next  = open_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.src    = SRC_PRE;
        cmd.idx    = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (op == OP_START) begin
                        cmd.start  = 1'b1;
                        open_next  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_PRE;
                    end else if (open_reg) begin
                        cmd.load_data = 1'b1;
                        state_next    = ST_DATA;
                    end
                end
            end
            ST_PRE: begin
                cmd.src = SRC_PRE;
                if (cnt_reg == sts.pre_cnt) begin
                    cnt_next   = '0;
                    state_next = ST_SYNC;
                end else if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = close_nocrc && sts.sync_cnt == '0 && sts.hdr_cnt == '0
                               && sts.fixed_len && (cnt_reg + 6'd1 == sts.pre_cnt);
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_SYNC: begin
                cmd.src = SRC_SYNC;
                if (cnt_reg == {3'b000, sts.sync_cnt}) begin
                    cnt_next   = '0;
                    state_next = ST_HDR;
                end else if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = close_nocrc && sts.hdr_cnt == '0 && sts.fixed_len
                               && (cnt_reg + 6'd1 == {3'b000, sts.sync_cnt});
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_HDR: begin
                cmd.src = SRC_HDR;
                if (cnt_reg == {3'b000, sts.hdr_cnt}) begin
                    cnt_next   = '0;
                    state_next = ST_LEN;
                end else if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = close_nocrc && sts.fixed_len
                               && (cnt_reg + 6'd1 == {3'b000, sts.hdr_cnt});
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_LEN: begin
                cmd.src = SRC_LEN;
                if (sts.fixed_len || sts.slot_free) begin
                    cmd.emit = !sts.fixed_len;
                    cmd.last = !sts.fixed_len && close_nocrc;
                    if (sts.len_zero) begin
                        open_next  = 1'b0;
                        state_next = sts.crc_on ? ST_CRC_HI : ST_IDLE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DATA: begin
                cmd.src = SRC_DATA;
                if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = !sts.crc_on && sts.rem_last;
                    if (sts.rem_last) begin
                        open_next  = 1'b0;
                        state_next = sts.crc_on ? ST_CRC_HI : ST_IDLE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CRC_HI: begin
                cmd.src = SRC_CRC_HI;
                if (sts.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CRC_LO;
                end
            end
            ST_CRC_LO: begin
                cmd.src = SRC_CRC_LO;
                if (sts.slot_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/rpf_dp.sv
// Framer datapath: config registers, CRC and PN9 state, byte encoder, output register.
`default_nettype none

module rpf_dp #(
    parameter int MAX_PAYLOAD = rpf_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [2:0]      cfg_addr,
    input  wire logic [31:0]     cfg_wr_data,
    input  wire logic [7:0]      payload_length,
    input  wire logic [7:0]      data_byte,
    input  wire rpf_pkg::dp_cmd_t cmd,
    output rpf_pkg::dp_sts_t     sts,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import rpf_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [6:0]  pre_nib_reg;
    logic [2:0]  sync_num_reg;
    logic [31:0] sync_reg;
    logic [2:0]  hdr_len_reg;
    logic [31:0] hdr_reg;
    logic [1:0]  crc_sel_reg;
    logic [7:0]  mode_reg;

    logic [15:0] crc_reg;
    logic [8:0]  lfsr_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;

    logic [6:0]  nib_sat;
    logic [7:0]  pre_sum;
    logic [7:0]  len_sat;
    logic [7:0]  pre_byte;
    logic [7:0]  crc_hi, crc_lo;
    logic [4:0]  byte_sh;
    logic [31:0] sync_sh, hdr_sh;
    logic [7:0]  raw;
    logic        whiten_en, feed_en;
    logic [8:0]  lfsr_adv;
    logic [7:0]  white;
    logic [7:0]  enc;
    logic [15:0] crc_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_nib_reg  <= RST_PRE_NIB;
            sync_num_reg <= RST_SYNC_LEN;
            sync_reg     <= RST_SYNC;
            hdr_len_reg  <= RST_HDR_LEN;
            hdr_reg      <= RST_HDR;
            crc_sel_reg  <= RST_CRC_SEL;
            mode_reg     <= RST_MODE;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_PRE_NIB:  pre_nib_reg  <= cfg_wr_data[6:0];
                REG_SYNC_LEN: sync_num_reg <= cfg_wr_data[2:0];
                REG_SYNC:     sync_reg     <= cfg_wr_data;
                REG_HDR_LEN:  hdr_len_reg  <= cfg_wr_data[2:0];
                REG_HDR:      hdr_reg      <= cfg_wr_data;
                REG_CRC_SEL:  crc_sel_reg  <= cfg_wr_data[1:0];
                REG_MODE:     mode_reg     <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Phase lengths, saturated.
    assign nib_sat      = (pre_nib_reg > PREAMBLE_MAX) ? PREAMBLE_MAX : pre_nib_reg;
    assign pre_sum      = {1'b0, nib_sat} + 8'd1;
    assign sts.pre_cnt  = pre_sum[6:1];
    assign sts.sync_cnt = (sync_num_reg > FIELD_MAX) ? FIELD_MAX : sync_num_reg;
    assign sts.hdr_cnt  = (hdr_len_reg > FIELD_MAX) ? FIELD_MAX : hdr_len_reg;
    assign sts.crc_on   = mode_reg[MF_CRC_ON];
    assign sts.fixed_len = mode_reg[MF_FIXED];
    assign sts.len_zero = (rem_reg == '0);
    assign sts.rem_last = (rem_reg == 8'd1);
    assign sts.slot_free = !out_valid_reg || m_tready;

    assign len_sat = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;

    always_comb begin
        if (mode_reg[MF_MANCH]) begin
            pre_byte = mode_reg[MF_POLARITY] ? PRE_MANCH_P1 : PRE_MANCH_P0;
        end else begin
            pre_byte = mode_reg[MF_POLARITY] ? PRE_PLAIN_P1 : PRE_PLAIN_P0;
        end
    end

    assign crc_hi  = mode_reg[MF_LSB] ? rev8(crc_reg[15:8]) : crc_reg[15:8];
    assign crc_lo  = mode_reg[MF_LSB] ? rev8(crc_reg[7:0]) : crc_reg[7:0];
    // Byte i of a 32-bit field sits at bits 31-8i down to 24-8i.
    assign byte_sh = {~cmd.idx, 3'b000};
    assign sync_sh = sync_reg >> byte_sh;
    assign hdr_sh  = hdr_reg >> byte_sh;

    always_comb begin
        case (cmd.src)
            SRC_PRE:    raw = pre_byte;
            SRC_SYNC:   raw = sync_sh[7:0];
            SRC_HDR:    raw = hdr_sh[7:0];
            SRC_LEN:    raw = rem_reg;
            SRC_DATA:   raw = data_reg;
            SRC_CRC_HI: raw = crc_hi;
            SRC_CRC_LO: raw = crc_lo;
            default:    raw = '0;
        endcase
        whiten_en = mode_reg[MF_WHITE]
                    && (cmd.src inside {SRC_HDR, SRC_LEN, SRC_DATA, SRC_CRC_HI, SRC_CRC_LO});
        feed_en   = (cmd.src == SRC_DATA)
                    || (!mode_reg[MF_CRC_DATA] && (cmd.src inside {SRC_HDR, SRC_LEN}));
    end

    assign lfsr_adv = pn9_step8(lfsr_reg);
    assign white    = whiten_en ? (raw ^ rev8(lfsr_adv[8:1])) : raw;
    assign enc      = (mode_reg[MF_LSB] ? white : rev8(white))
                      ^ ((mode_reg[MF_MANCH] && mode_reg[MF_MINV]) ? BYTE_INVERT : 8'h00);
    assign crc_new  = crc_byte(crc_reg, mode_reg[MF_LSB] ? rev8(raw) : raw,
                               POLY_TABLE[crc_sel_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= '0;
            lfsr_reg <= PN9_SEED;
            rem_reg  <= '0;
        end else if (cmd.start) begin
            crc_reg  <= '0;
            lfsr_reg <= PN9_SEED;
            rem_reg  <= len_sat;
        end else if (cmd.emit) begin
            if (feed_en) begin
                crc_reg <= crc_new;
            end
            if (whiten_en) begin
                lfsr_reg <= lfsr_adv;
            end
            if (cmd.src == SRC_DATA) begin
                rem_reg <= rem_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_data) begin
            data_reg <= data_byte;
        end
    end

    // Output register: load on emit, drop once the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= enc;
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### src/radio_packet_framer_top.sv
// Radio packet framer top level: sequencer plus datapath.
//
// Usage:
//   s_ channel takes items. tuser is the operation (0 start of packet, 1 payload byte);
//   a start item reads payload_length, a payload item reads data_byte.
//   m_ channel gives encoded frame bytes in transmit order; tlast marks the last
//   byte of a frame. cfg_wr_en/cfg_addr/cfg_wr_data write one register per edge;
//   write only while the block is idle.
// Sequencing:
//   s_tready is high only while the sequencer is idle. A start item is captured, then
//   the sequencer emits each preamble, sync and header byte, steps out of each of those
//   three phases, runs the length phase with or without its byte, and emits the two
//   CRC bytes when it closes the packet with CRC. A payload item is captured, then
//   emitted, with the two CRC bytes after it when it closes the packet with CRC; an
//   item outside a packet is dropped. Each byte is on m_ the cycle after its emit cycle.
//   The emit path gives at most one byte per cycle, only while the output slot is free.
// Reset (aresetn low, synchronous): registers return to defaults, no packet open,
//   the output register empties.
// Stall: with m_tready low the output register holds its byte and the sequencer
//   holds its place; emission resumes on the next transfer.
`default_nettype none
`include "assert_macros.svh"

module radio_packet_framer_top #(
    parameter int MAX_PAYLOAD = rpf_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [7:0] payload_length, [15:8] data_byte
    input  wire logic        s_tuser,     // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // [7:0] frame_byte
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wr_data
);
    import rpf_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpf_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .payload_length (s_tdata[7:0]),
        .data_byte      (s_tdata[15:8]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

    // Never overwrite a byte still waiting for its transfer.
    `RPF_ASSERT(a_emit_slot, aclk, aresetn, cmd.emit, sts.slot_free, "emit into busy output")
    // The idle sequencer emits nothing.
    `RPF_ASSERT(a_idle_quiet, aclk, aresetn, s_tready, !cmd.emit, "emit while accepting input")
    // A frame-ending byte shows up on the output with tlast.
    `RPF_ASSERT_NEXT(a_last_out, aclk, aresetn, cmd.emit && cmd.last, m_tvalid && m_tlast, "no tlast")

endmodule

`default_nettype wire

### tb/sv/tb_radio_packet_framer_top.sv
// Self-checking testbench for the radio packet framer: predicts every frame byte and checks it.
`timescale 1ns / 100ps

module tb_radio_packet_framer_top;
    import rpf_pkg::*;

    // Limits of the framing format, kept apart from the design's own constants.
    localparam int unsigned PRE_NIBBLE_CAP = 106;
    localparam int unsigned FIELD_CAP      = 4;
    localparam int unsigned PAYLOAD_CAP    = 249;
    localparam logic [8:0]  PN9_INIT       = 9'h1FF;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned LONG_HOLD      = 400;

    // Frame byte predictor plus store of the bytes still owed by the block.
    class frame_byte_tracker;
        logic [6:0]  pre_nibbles;
        logic [2:0]  sync_count;
        logic [31:0] sync_pattern;
        logic [2:0]  hdr_count;
        logic [31:0] hdr_word;
        logic [1:0]  poly_sel;
        logic [7:0]  mode;
        logic [15:0] crc_acc;
        logic [8:0]  pn9;
        logic [7:0]  left_in_packet;
        bit          in_packet;
        logic [7:0]  want_byte[$];
        bit          want_end[$];
        int unsigned mismatches;

        function new();
            pre_nibbles    = 7'd8;
            sync_count     = 3'd2;
            sync_pattern   = 32'h2DA4_0000;
            hdr_count      = 3'd2;
            hdr_word       = 32'h0000_0000;
            poly_sel       = 2'd1;
            mode           = 8'h45;
            crc_acc        = 16'h0000;
            pn9            = PN9_INIT;
            left_in_packet = 8'd0;
            in_packet      = 1'b0;
            mismatches     = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_PRE_NIB:  pre_nibbles  = value[6:0];
                REG_SYNC_LEN: sync_count   = value[2:0];
                REG_SYNC:     sync_pattern = value;
                REG_HDR_LEN:  hdr_count    = value[2:0];
                REG_HDR:      hdr_word     = value;
                REG_CRC_SEL:  poly_sel     = value[1:0];
                REG_MODE:     mode         = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] flip8(logic [7:0] v);
            return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
        endfunction

        function logic [15:0] poly_for(logic [1:0] sel);
            case (sel)
                2'd0:    return 16'h1021;
                2'd1:    return 16'h8005;
                2'd2:    return 16'h5B93;
                default: return 16'h90D9;
            endcase
        endfunction

        function void crc_update(logic [7:0] v);
            logic [15:0] c;
            logic [15:0] p;
            p = poly_for(poly_sel);
            c = crc_acc ^ {(mode[MF_LSB] ? flip8(v) : v), 8'h00};
            repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ p) : {c[14:0], 1'b0};
            crc_acc = c;
        endfunction

        // Advance PN9 by one byte and mask; pass through when whitening is off.
        function logic [7:0] whiten(logic [7:0] v);
            logic [8:0] s;
            if (!mode[MF_WHITE])
                return v;
            s = pn9;
            repeat (8) s = {s[5] ^ s[0], s[8:1]};
            pn9 = s;
            return v ^ flip8(s[8:1]);
        endfunction

        // Apply line order and Manchester inversion, then queue the byte.
        function void queue_byte(logic [7:0] v);
            logic [7:0] b;
            b = mode[MF_LSB] ? v : flip8(v);
            if (mode[MF_MANCH] && mode[MF_MINV])
                b = ~b;
            want_byte.push_back(b);
            want_end.push_back(1'b0);
        endfunction

        function void close_packet(int unsigned mark);
            logic [7:0] hi;
            logic [7:0] lo;
            if (mode[MF_CRC_ON]) begin
                hi = crc_acc[15:8];
                lo = crc_acc[7:0];
                if (mode[MF_LSB]) begin
                    hi = flip8(hi);
                    lo = flip8(lo);
                end
                queue_byte(whiten(hi));
                queue_byte(whiten(lo));
            end
            // Flag the last byte this item produced, if it produced any.
            if (want_byte.size() > mark)
                want_end[want_end.size() - 1] = 1'b1;
            in_packet = 1'b0;
        endfunction

        // Note one accepted input transfer and queue the bytes it owes.
        function void take_item(logic op, logic [7:0] len_field, logic [7:0] data_field);
            int unsigned mark;
            int unsigned n_pre;
            int unsigned n_sync;
            int unsigned n_hdr;
            logic [7:0]  pre;
            logic [7:0]  plen;
            logic [7:0]  hb;
            bit          hdr_in_crc;
            mark = want_byte.size();
            if (op == OP_START) begin
                n_pre  = (pre_nibbles > PRE_NIBBLE_CAP) ? PRE_NIBBLE_CAP : pre_nibbles;
                n_pre  = (n_pre + 1) / 2;
                n_sync = (sync_count > FIELD_CAP) ? FIELD_CAP : sync_count;
                n_hdr  = (hdr_count > FIELD_CAP) ? FIELD_CAP : hdr_count;
                if (mode[MF_MANCH])
                    pre = mode[MF_POLARITY] ? 8'hff : 8'h00;
                else
                    pre = mode[MF_POLARITY] ? 8'h55 : 8'haa;
                crc_acc        = 16'h0000;
                pn9            = PN9_INIT;
                in_packet      = 1'b1;
                plen           = (len_field > PAYLOAD_CAP) ? PAYLOAD_CAP[7:0] : len_field;
                left_in_packet = plen;
                hdr_in_crc     = !mode[MF_CRC_DATA];
                repeat (n_pre) queue_byte(pre);
                for (int k = 0; k < n_sync; k++)
                    queue_byte(sync_pattern[31 - 8 * k -: 8]);
                for (int k = 0; k < n_hdr; k++) begin
                    hb = hdr_word[31 - 8 * k -: 8];
                    if (hdr_in_crc)
                        crc_update(hb);
                    queue_byte(whiten(hb));
                end
                if (!mode[MF_FIXED]) begin
                    if (hdr_in_crc)
                        crc_update(plen);
                    queue_byte(whiten(plen));
                end
                if (left_in_packet == 0)
                    close_packet(mark);
            end else if (in_packet) begin
                crc_update(data_field);
                queue_byte(whiten(data_field));
                left_in_packet = left_in_packet - 8'd1;
                if (left_in_packet == 0)
                    close_packet(mark);
            end
        endfunction

        // Compare one output transfer with the oldest owed byte.
        function void check_byte(logic [7:0] got_byte, logic got_end);
            logic [7:0] exp_byte;
            bit         exp_end;
            if (want_byte.size() == 0) begin
                $error("frame_byte %02h (frame_end %0b) arrived with no byte owed",
                       got_byte, got_end);
                mismatches++;
                return;
            end
            exp_byte = want_byte.pop_front();
            exp_end  = want_end.pop_front();
            if (got_byte !== exp_byte) begin
                $error("frame_byte mismatch: expected %02h, got %02h", exp_byte, got_byte);
                mismatches++;
            end
            if (got_end !== exp_end) begin
                $error("frame_end mismatch: expected %0b, got %0b", exp_end, got_end);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [7:0] payload_length, [15:8] data_byte
    logic        s_tuser;     // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [7:0] frame_byte
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wr_data;

    frame_byte_tracker tracker;

    // Shared pacing knobs: sender gap odds, calm tail, one-off long receiver hold.
    int unsigned gap_pct = 0;
    bit          quiet = 1'b0;
    bit          hold_off_req = 1'b0;

    radio_packet_framer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // Offer one item, with an optional idle burst first; hold it until the transfer.
    task automatic offer_item(input logic op, input logic [7:0] len_field,
                              input logic [7:0] data_field);
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data_field, len_field};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_item(op, len_field, data_field);
    endtask

    // The field an item does not use carries random bits.
    task automatic send_start(input logic [7:0] plen);
        offer_item(OP_START, plen, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_data(input logic [7:0] b);
        offer_item(OP_DATA, 8'($urandom_range(0, 255)), b);
    endtask

    // Write all seven registers back to back; the block must be idle.
    task automatic program_regs(input logic [6:0] nib, input logic [2:0] sync_num,
                                input logic [31:0] sync_w, input logic [2:0] hdr_len,
                                input logic [31:0] hdr_w, input logic [1:0] crc_sel,
                                input logic [7:0] mode_bits);
        logic [31:0] vals [7];
        reg_idx_t    r;
        vals[0] = 32'(nib);
        vals[1] = 32'(sync_num);
        vals[2] = sync_w;
        vals[3] = 32'(hdr_len);
        vals[4] = hdr_w;
        vals[5] = 32'(crc_sel);
        vals[6] = 32'(mode_bits);
        for (int k = 0; k < 7; k++) begin
            r = reg_idx_t'(k);
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= r;
            cfg_wr_data <= vals[k];
            tracker.set_reg(r, vals[k]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic shuffle_settings();
        program_regs(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)), $urandom,
                     3'($urandom_range(0, 7)), $urandom, 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)));
    endtask

    // Drop valid, wait until every owed byte is out, then let the sequencer go idle.
    task automatic drain_and_rest();
        s_tvalid <= 1'b0;
        while (tracker.want_byte.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly complete packets with random content; some cut short by a new start,
    // some stray payload bytes. Stray bytes outside a packet are not counted.
    task automatic random_phase(input int unsigned budget, input bit with_long_packet);
        int unsigned sent;
        int unsigned plen;
        int unsigned ndata;
        int unsigned kind;
        sent = 0;
        if (with_long_packet) begin
            // Oversized length: saturates, then the full payload follows.
            send_start(8'd255);
            repeat (PAYLOAD_CAP) send_data(8'($urandom_range(0, 255)));
            sent += PAYLOAD_CAP + 1;
        end
        while (sent < budget) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                if (tracker.in_packet)
                    sent++;
                send_data(8'($urandom_range(0, 255)));
            end else if (kind == 1) begin
                plen  = $urandom_range(3, 20);
                ndata = $urandom_range(0, plen - 1);
                send_start(8'(plen));
                repeat (ndata) send_data(8'($urandom_range(0, 255)));
                sent += 1 + ndata;
            end else begin
                if ($urandom_range(0, 79) == 0)
                    plen = $urandom_range(200, 255);
                else
                    plen = $urandom_range(0, 12);
                ndata = (plen > PAYLOAD_CAP) ? PAYLOAD_CAP : plen;
                send_start(8'(plen));
                repeat (ndata) send_data(8'($urandom_range(0, 255)));
                sent += 1 + ndata;
            end
        end
    endtask

    // Receiver: random stall bursts, calm stretches, and one long hold-off
    // so that the output register fills and the block stalls its input.
    initial begin : result_sink
        int unsigned burst_left;
        int unsigned calm_left;
        int unsigned hold_left;
        int unsigned r;
        bit          hold_done;
        burst_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else if (calm_left != 0) begin
                calm_left--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    burst_left = $urandom_range(1, 12) - 1;
                    m_tready <= 1'b0;
                end else begin
                    if (r > 96)
                        calm_left = $urandom_range(30, 150);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Check each output transfer against the oldest owed byte.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_byte(m_tdata, m_tlast);
    end

    initial begin : stimulus
        tracker = new();
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= OP_START;
        s_tdata     <= 16'h0000;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_PRE_NIB;
        cfg_wr_data <= 32'h0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: short packet with extreme bytes, a stray byte, empty payload.
        send_start(8'd3);
        send_data(8'h00);
        send_data(8'hff);
        send_data(8'h5a);
        send_data(8'h33);
        send_start(8'd0);
        drain_and_rest();

        // Every flag on, every length over its cap; restart inside an open packet.
        program_regs(7'd127, 3'd7, 32'hffff_ffff, 3'd7, 32'hffff_ffff, 2'd0, 8'hff);
        send_start(8'd255);
        send_data(8'hff);
        send_data(8'h00);
        send_start(8'd2);
        send_data(8'h80);
        send_data(8'h01);
        drain_and_rest();

        // Nothing to send at all, then a frame of a single byte.
        program_regs(7'd0, 3'd0, 32'h0000_0000, 3'd0, 32'hffff_ffff, 2'd2, 8'h02);
        send_start(8'd0);
        send_start(8'd1);
        send_data(8'ha5);
        drain_and_rest();

        // Manchester with polarity low, whitening, CRC over data only.
        program_regs(7'd1, 3'd4, 32'ha5c3_0ff0, 3'd4, 32'h1234_5678, 2'd3, 8'hac);
        send_start(8'd2);
        send_data(8'h7e);
        send_data(8'h81);
        drain_and_rest();

        // All flags off; length byte carries the saturated payload count.
        program_regs(7'd106, 3'd1, 32'h0000_0000, 3'd1, 32'h8000_0000, 2'd1, 8'h00);
        send_start(8'd250);
        send_start(8'd1);
        send_data(8'h00);
        send_data(8'hff);
        drain_and_rest();

        // Random settings per phase; vary the sender's gap density between phases.
        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            shuffle_settings();
            if (ph == 0)
                hold_off_req = 1'b1;
            random_phase(40, ph == 2);
            drain_and_rest();
        end

        // Calm tail: no idling on either side.
        quiet = 1'b1;
        shuffle_settings();
        random_phase(40, 1'b0);
        drain_and_rest();

        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
